>>> src/gwm_pkg.sv
// ----------------------------------------------------------------------------
// gwm_pkg
// shared op codes, pattern byte codes and cell interface types for the
// glob wildcard matcher
// ----------------------------------------------------------------------------
package gwm_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_TARGET = 2'd2,
    OP_END    = 2'd3
  } gwm_op_t;

  localparam logic [7:0] STAR_BYTE = 8'h2A;
  localparam logic [7:0] ANY_BYTE  = 8'h3F;

  // controls broadcast to every cell of the row
  typedef struct packed {
    logic clear;   // drop the pattern
    logic step;    // advance the reached set by one target byte
    logic rearm;   // reached set back to position zero only
  } gwm_ctrl_t;

  // what each cell reports to the rest of the row
  typedef struct packed {
    logic reached; // raw reached bit of this position
    logic valid;   // position holds a pattern byte
    logic star;    // pattern byte is a star
    logic match;   // reach handed to the next position on a step
  } gwm_cell_status_t;

endpackage

>>> src/gwm_cell.sv
// ----------------------------------------------------------------------------
// gwm_cell
// one pattern position: holds its pattern byte and its reached bit, and
// hands a matched reach to its right-hand neighbor on every target byte
// ----------------------------------------------------------------------------
module gwm_cell #(
  parameter bit FIRST = 1'b0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  gwm_pkg::gwm_ctrl_t         ctrl,
  input  logic                       write_en,
  input  logic [7:0]                 symbol,
  input  logic                       closed,
  input  logic                       match_in,
  output gwm_pkg::gwm_cell_status_t  status
);
  import gwm_pkg::*;

  logic [7:0] pattern_byte;
  logic       valid;
  logic       star;
  logic       reached;
  logic       reached_next;
  logic       hit;

  // a closed reach on a star stays put; on a non-star byte it moves right only on a hit
  assign hit          = (pattern_byte == ANY_BYTE) || (pattern_byte == symbol);
  assign reached_next = (closed & valid & star) | match_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid   <= 1'b0;
      reached <= FIRST;
    end else begin
      if (ctrl.clear) begin
        valid <= 1'b0;
      end else if (write_en) begin
        valid <= 1'b1;
      end
      if (ctrl.rearm) begin
        reached <= FIRST;
      end else if (ctrl.step) begin
        reached <= reached_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (write_en) begin
      pattern_byte <= symbol;
      star         <= (symbol == STAR_BYTE);
    end
  end

  assign status.reached = reached;
  assign status.valid   = valid;
  assign status.star    = star;
  assign status.match   = closed & valid & ~star & hit;

endmodule

>>> src/gwm_star_closure.sv
// ----------------------------------------------------------------------------
// gwm_star_closure
// extends the raw reached set across runs of stars with a parallel prefix,
// so a reach entering a star run covers the whole run combinationally
// ----------------------------------------------------------------------------
module gwm_star_closure #(
  parameter int DEPTH = 65
) (
  input  logic [DEPTH-1:0] raw,
  input  logic [DEPTH-2:0] prop,
  output logic [DEPTH-1:0] closed
);

  localparam int LEVELS = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // gen[l][k]: position k reached from somewhere within 2^l positions
  // pass[l][k]: a reach 2^l positions left of k carries through to k
  logic [LEVELS:0][DEPTH-1:0] gen;
  logic [LEVELS:0][DEPTH-1:0] pass;

  always_comb begin
    gen[0]  = raw;
    pass[0] = {prop, 1'b0};
    for (int l = 0; l < LEVELS; l++) begin
      for (int k = 0; k < DEPTH; k++) begin
        if (k >= (1 << l)) begin
          gen[l+1][k]  = gen[l][k] | (pass[l][k] & gen[l][k-(1<<l)]);
          pass[l+1][k] = pass[l][k] & pass[l][k-(1<<l)];
        end else begin
          gen[l+1][k]  = gen[l][k];
          pass[l+1][k] = pass[l][k];
        end
      end
    end
    closed = gen[LEVELS];
  end

endmodule

>>> src/glob_wildcard_match_unit.sv
// ----------------------------------------------------------------------------
// glob_wildcard_match_unit
// glob matcher with '*' and '?' over a pattern loaded one byte at a time
// ----------------------------------------------------------------------------
// The pattern lives in a row of MAX_PATTERN cells, one per pattern byte, plus
// a terminal position past the last byte. op 0 clears the pattern and the
// overflow flag, op 1 appends a byte (dropped, with overflow set, once the row
// is full), op 2 feeds one target byte and op 3 ends the target: it returns
// matched and overflow as one result transaction and rearms the row for the
// next target while keeping the pattern. A new transaction can be accepted on
// every clock except while an op 3 is held off; the per-byte path is the star
// closure prefix (log2 of MAX_PATTERN+1 levels) followed by each cell's byte
// compare. The result lands in an output register in the cycle after op 3 is
// accepted. While that register is full and stalled, only an op 3 is held
// off; pattern and target bytes keep flowing.
// ----------------------------------------------------------------------------
module glob_wildcard_match_unit #(
  parameter int MAX_PATTERN = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_stall,
  input  logic [1:0] op,
  input  logic [7:0] symbol,
  output logic       result_valid,
  input  logic       result_stall,
  output logic       matched,
  output logic       overflow
);
  import gwm_pkg::*;

  localparam int DEPTH = MAX_PATTERN + 1;
  localparam int LEN_W = $clog2(MAX_PATTERN + 1);

  gwm_ctrl_t                    ctrl;
  gwm_cell_status_t             status [MAX_PATTERN];
  logic [MAX_PATTERN-1:0]       write_en;
  logic [MAX_PATTERN:0]         match_chain;
  logic [DEPTH-1:0]             raw;
  logic [DEPTH-2:0]             prop;
  logic [DEPTH-1:0]             closed;

  logic [LEN_W-1:0]             pattern_length;
  logic                         overflow_flag;
  logic                         term_reached;

  logic                         accept;
  logic                         full;
  logic                         do_append;
  logic                         do_end;
  logic                         end_hit;

  // only an end of target needs the output register
  assign item_stall = result_valid & result_stall & (gwm_op_t'(op) == OP_END);
  assign accept     = item_valid & ~item_stall;
  assign full       = (pattern_length == LEN_W'(MAX_PATTERN));

  always_comb begin
    ctrl      = '0;
    do_append = 1'b0;
    do_end    = 1'b0;
    if (accept) begin
      case (gwm_op_t'(op))
        OP_CLEAR: begin
          ctrl.clear = 1'b1;
          ctrl.rearm = 1'b1;
        end
        OP_APPEND: begin
          do_append = 1'b1;
        end
        OP_TARGET: begin
          ctrl.step = 1'b1;
        end
        OP_END: begin
          ctrl.rearm = 1'b1;
          do_end     = 1'b1;
        end
        default: begin
          ctrl = '0;
        end
      endcase
    end
  end

  // the cell row; reach moves left to right through match_chain
  assign match_chain[0] = 1'b0;

  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign write_en[i] = do_append & ~full & (pattern_length == LEN_W'(i));

    gwm_cell #(
      .FIRST (i == 0)
    ) u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctrl     (ctrl),
      .write_en (write_en[i]),
      .symbol   (symbol),
      .closed   (closed[i]),
      .match_in (match_chain[i]),
      .status   (status[i])
    );

    assign match_chain[i+1] = status[i].match;
    assign raw[i]           = status[i].reached;
    // a loaded star passes its reach on without consuming a byte
    assign prop[i]          = status[i].valid & status[i].star;
  end

  assign raw[MAX_PATTERN] = term_reached;

  gwm_star_closure #(
    .DEPTH (DEPTH)
  ) u_closure (
    .raw    (raw),
    .prop   (prop),
    .closed (closed)
  );

  // the end of the pattern is the first position without a byte; nothing is
  // ever reached past it, so any closed position without a byte is the end
  always_comb begin
    end_hit = closed[MAX_PATTERN];
    for (int k = 0; k < MAX_PATTERN; k++) begin
      end_hit = end_hit | (closed[k] & ~status[k].valid);
    end
  end

  // pattern length, sticky overflow and the terminal position
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      overflow_flag  <= 1'b0;
      term_reached   <= 1'b0;
    end else begin
      if (ctrl.clear) begin
        pattern_length <= '0;
        overflow_flag  <= 1'b0;
      end else if (do_append) begin
        if (full) begin
          overflow_flag <= 1'b1;
        end else begin
          pattern_length <= pattern_length + LEN_W'(1);
        end
      end
      // the end of the pattern matches no byte, so it only takes a reach in
      if (ctrl.rearm) begin
        term_reached <= 1'b0;
      end else if (ctrl.step) begin
        term_reached <= match_chain[MAX_PATTERN];
      end
    end
  end

  // output register for the result transaction
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (do_end) begin
      result_valid <= 1'b1;
    end else if (~result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_end) begin
      matched  <= end_hit;
      overflow <= overflow_flag;
    end
  end

endmodule
